/* hw/rtl/lic_pkg.sv */
// Package for the linear index to coordinates block.
// Holds widths, the register index codes and the word type passed along the cell chain.
// No dependencies.
package lic_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int NUM_COORDS = 4;
  localparam int DIM_CAP    = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;
  localparam int IDX_W      = 32;
  localparam int SIZE_W     = 16;
  localparam int NDIMS_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEPS      = IDX_W;
  localparam int NUM_CELLS  = NUM_COORDS * STEPS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIMS  = 3'd0,
    CFG_SIZE_DIM0 = 3'd1,
    CFG_SIZE_DIM1 = 3'd2,
    CFG_SIZE_DIM2 = 3'd3,
    CFG_SIZE_DIM3 = 3'd4
  } cfg_idx_e;

  typedef logic [NUM_COORDS-1:0][SIZE_W-1:0] lic_coords_t;

  // Partial quotient shifts left through work; rem is the running remainder.
  typedef struct packed {
    logic [IDX_W-1:0]  work;
    logic [SIZE_W-1:0] rem;
    lic_coords_t       coords;
  } lic_word_t;

endpackage

/* hw/rtl/lic_if.sv */
// Channel interfaces of the linear index to coordinates block.
// Depends on lic_pkg for the field widths.
interface lic_idx_if import lic_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] linear_index;
  modport source (output valid, output linear_index, input ready);
  modport sink (input valid, input linear_index, output ready);
endinterface

interface lic_coord_if import lic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] coord0;
  logic [SIZE_W-1:0] coord1;
  logic [SIZE_W-1:0] coord2;
  logic [SIZE_W-1:0] coord3;
  modport source (output valid, output coord0, output coord1, output coord2, output coord3,
                  input ready);
  modport sink (input valid, input coord0, input coord1, input coord2, input coord3,
                output ready);
endinterface

interface lic_cfg_if import lic_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/linear_index_to_coordinates.sv */
// Top level: configuration registers, a chain of division cells and the output buffer.
// Depends on lic_pkg, the lic interfaces, lic_cell and lic_skid.
//
//  channel | dir | word
//  in_i    | in  | linear_index
//  out_o   | out | coord0, coord1, coord2, coord3
//  cfg_i   | in  | index, data (always ready)
//
// One index enters per cycle while the skid stage is empty; a result passes one cell per
// quotient bit, 32 cells per dimension over four dimensions, then the output register.
// Reset clears all valid flags and sets the dimension count and every extent to 1.
// A stalled output parks one word in the skid stage; the chain then holds until it drains.
module linear_index_to_coordinates import lic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lic_idx_if.sink   in_i,
  lic_coord_if.source out_o,
  lic_cfg_if.sink   cfg_i
);

  logic [NDIMS_W-1:0] num_dims_q;
  logic [NUM_COORDS-1:0][SIZE_W-1:0] size_q;
  logic [NDIMS_W-1:0] active;
  logic [NUM_COORDS-1:0][SIZE_W-1:0] divisor;
  logic en;

  logic      cell_valid_in [NUM_CELLS];
  lic_word_t cell_word_in  [NUM_CELLS];
  logic      cell_valid_out [NUM_CELLS];
  lic_word_t cell_word_out  [NUM_CELLS];
  lic_coords_t final_coords;

  // Configuration writes; indexes past the list are dropped.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= NDIMS_W'(1);
      for (int i = 0; i < NUM_COORDS; i++) begin
        size_q[i] <= SIZE_W'(1);
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_NUM_DIMS:  num_dims_q <= cfg_i.data[NDIMS_W-1:0];
        CFG_SIZE_DIM0: size_q[0] <= cfg_i.data;
        CFG_SIZE_DIM1: size_q[1] <= cfg_i.data;
        CFG_SIZE_DIM2: size_q[2] <= cfg_i.data;
        CFG_SIZE_DIM3: size_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A zero extent or a dimension out of use divides by one, leaving coordinate 1.
  always_comb begin
    active = num_dims_q;
    if (active == '0) begin
      active = NDIMS_W'(1);
    end
    if (active > NDIMS_W'(DIM_CAP)) begin
      active = NDIMS_W'(DIM_CAP);
    end
    for (int d = 0; d < NUM_COORDS; d++) begin
      if (size_q[d] == '0 || NDIMS_W'(d) >= active) begin
        divisor[d] = SIZE_W'(1);
      end else begin
        divisor[d] = size_q[d];
      end
    end
  end

  assign in_i.ready = en;

  // The chain; at each dimension boundary the remainder becomes a coordinate
  // and the quotient becomes the next dividend.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      always_comb begin
        cell_valid_in[k]       = in_i.valid;
        cell_word_in[k].work   = in_i.linear_index;
        cell_word_in[k].rem    = '0;
        cell_word_in[k].coords = '0;
      end
    end else if (k % STEPS == 0) begin : g_bound
      always_comb begin
        cell_valid_in[k]     = cell_valid_out[k-1];
        cell_word_in[k]      = cell_word_out[k-1];
        cell_word_in[k].rem  = '0;
        cell_word_in[k].coords[k/STEPS-1] = cell_word_out[k-1].rem + SIZE_W'(1);
      end
    end else begin : g_link
      assign cell_valid_in[k] = cell_valid_out[k-1];
      assign cell_word_in[k]  = cell_word_out[k-1];
    end

    lic_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (divisor[k/STEPS]),
      .valid_i   (cell_valid_in[k]),
      .word_i    (cell_word_in[k]),
      .valid_o   (cell_valid_out[k]),
      .word_o    (cell_word_out[k])
    );
  end

  // The last dimension's remainder is filled in at the chain's end.
  always_comb begin
    final_coords = cell_word_out[NUM_CELLS-1].coords;
    final_coords[NUM_COORDS-1] = cell_word_out[NUM_CELLS-1].rem + SIZE_W'(1);
  end

  lic_skid u_skid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cell_valid_out[NUM_CELLS-1]),
    .coords_i (final_coords),
    .en_o     (en),
    .out_o    (out_o)
  );

endmodule

/* hw/rtl/lic_cell.sv */
// One restoring division step: brings in one dividend bit and emits one quotient bit.
// Depends on lic_pkg for the word type.
module lic_cell import lic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [SIZE_W-1:0] divisor_i,
  input  logic              valid_i,
  input  lic_word_t         word_i,
  output logic              valid_o,
  output lic_word_t         word_o
);

  logic        valid_q;
  lic_word_t   word_q, word_d;
  logic [SIZE_W:0] trial;
  logic [SIZE_W:0] diff;
  logic        ge;

  // Shift the next dividend bit into the remainder and try the subtraction.
  always_comb begin
    trial  = {word_i.rem, word_i.work[IDX_W-1]};
    diff   = trial - {1'b0, divisor_i};
    ge     = (trial >= {1'b0, divisor_i});
    word_d = word_i;
    word_d.work = {word_i.work[IDX_W-2:0], ge};
    word_d.rem  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* hw/rtl/lic_skid.sv */
// Output register with a skid stage that catches one word while the output word waits.
// Depends on lic_pkg and the lic_coord_if interface.
module lic_skid import lic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  lic_coords_t coords_i,
  output logic        en_o,
  lic_coord_if.source out_o
);

  logic        out_valid_q, skid_valid_q;
  lic_coords_t out_q, skid_q;
  logic        drain;

  assign drain = out_o.ready || !out_valid_q;
  assign en_o  = !skid_valid_q;

  // Control: the skid fills only when the output word is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= valid_i;
      end
    end else if (valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload moves with the control above.
  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_valid_q ? skid_q : coords_i;
    end else if (!skid_valid_q) begin
      skid_q <= coords_i;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.coord0 = out_q[0];
  assign out_o.coord1 = out_q[1];
  assign out_o.coord2 = out_q[2];
  assign out_o.coord3 = out_q[3];

endmodule
